>>> design/rcs_pkg.sv
// ----------------------------------------------------------------------------
// rcs_pkg
// Shared types and codes for the bistable relay coil sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package rcs_pkg;

    // opcodes of an input item
    localparam logic [1:0] OP_TICK   = 2'd0;
    localparam logic [1:0] OP_SET    = 2'd1;
    localparam logic [1:0] OP_PULSE  = 2'd2;
    localparam logic [1:0] OP_TOGGLE = 2'd3;

    // expander bytes driven to the coil
    localparam logic [7:0] PORT_ON  = 8'h30;
    localparam logic [7:0] PORT_OFF = 8'hC0;
    localparam logic [7:0] PORT_REL = 8'h50;

    // believed relay position
    localparam logic [1:0] ST_UNKNOWN = 2'd0;
    localparam logic [1:0] ST_OFF     = 2'd1;
    localparam logic [1:0] ST_ON      = 2'd2;

    // pending command
    localparam logic [1:0] CMD_NONE  = 2'd0;
    localparam logic [1:0] CMD_SET   = 2'd1;
    localparam logic [1:0] CMD_PULSE = 2'd2;

    // configuration register indexes
    localparam int unsigned CFG_IDX_BITS = 1;
    localparam logic [CFG_IDX_BITS-1:0] REG_ENERGIZE = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_RECHARGE = 1'd1;

    localparam int unsigned CFG_BITS        = 16;
    localparam logic [15:0] ENERGIZE_RESET  = 16'd20;
    localparam logic [15:0] RECHARGE_RESET  = 16'd100;

    typedef struct packed {
        logic [1:0]  opcode;
        logic        target_on;
        logic [23:0] pulse_ticks;
    } t_rcs_in;

    typedef struct packed {
        logic [7:0] coil_port;
        logic [1:0] relay_state;
        logic       busy_res;
    } t_rcs_out;

endpackage

`default_nettype wire

>>> design/rcs_core.sv
// ----------------------------------------------------------------------------
// rcs_core
// Sequencer state, configuration registers and the single-pass update that
// applies one tick or command and yields the result of that item.
// ----------------------------------------------------------------------------
`default_nettype none

module rcs_core import rcs_pkg::*; #(
    parameter int unsigned TICK_BITS = 24
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_step,
    input  wire t_rcs_in                 i_item,
    output t_rcs_out                     o_result,
    input  wire logic                    i_cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0] i_cfg_index,
    input  wire logic [CFG_BITS-1:0]     i_cfg_data
);

    localparam int unsigned W = TICK_BITS;

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_SET_HOLD = 3'd1,
        PH_PUL_HOLD = 3'd2,
        PH_PUL_GAP  = 3'd3,
        PH_REV_HOLD = 3'd4
    } t_phase;

    t_phase         r_phase,   n_phase;
    logic [W-1:0]   r_wait,    n_wait;
    logic [1:0]     r_pending, n_pending;
    logic           r_wanted,  n_wanted;
    logic [W-1:0]   r_pulse,   n_pulse;
    logic [1:0]     r_believed, n_believed;
    logic [7:0]     r_port,    n_port;
    logic [15:0]    r_energize;
    logic [15:0]    r_recharge;

    logic [W-1:0]   energize_w;
    logic [W-1:0]   recharge_w;
    logic [W-1:0]   dur_w;

    function automatic logic [W-1:0] wait_for(input logic [W-1:0] n);
        return (n == '0) ? '0 : n - W'(1);
    endfunction

    // saturate durations into the tick counter width
    generate
        if (W >= 16) begin : g_cfg_wide
            assign energize_w = W'(r_energize);
            assign recharge_w = W'(r_recharge);
        end else begin : g_cfg_narrow
            assign energize_w = (|r_energize[15:W]) ? '1 : r_energize[W-1:0];
            assign recharge_w = (|r_recharge[15:W]) ? '1 : r_recharge[W-1:0];
        end
        if (W >= 24) begin : g_dur_wide
            assign dur_w = W'(i_item.pulse_ticks);
        end else begin : g_dur_narrow
            assign dur_w = (|i_item.pulse_ticks[23:W]) ? '1 : i_item.pulse_ticks[W-1:0];
        end
    endgenerate

    always_comb begin
        n_phase    = r_phase;
        n_wait     = r_wait;
        n_pending  = r_pending;
        n_wanted   = r_wanted;
        n_pulse    = r_pulse;
        n_believed = r_believed;
        n_port     = r_port;
        case (i_item.opcode)
            OP_TICK: begin
                if (r_wait != '0) begin
                    n_wait = r_wait - W'(1);
                end else begin
                    unique case (r_phase)
                        PH_SET_HOLD, PH_REV_HOLD: begin
                            n_port  = PORT_REL;
                            n_phase = PH_IDLE;
                            n_wait  = wait_for(recharge_w);
                        end
                        PH_PUL_HOLD: begin
                            n_port  = PORT_REL;
                            n_phase = PH_PUL_GAP;
                            n_wait  = wait_for(r_pulse);
                        end
                        PH_PUL_GAP: begin
                            n_believed = (r_believed == ST_ON) ? ST_OFF : ST_ON;
                            n_port     = (r_believed == ST_ON) ? PORT_OFF : PORT_ON;
                            n_phase    = PH_REV_HOLD;
                            n_wait     = wait_for(energize_w);
                        end
                        default: begin
                            n_phase = PH_IDLE;
                            if (r_pending == CMD_SET || r_pending == CMD_PULSE) begin
                                n_phase    = (r_pending == CMD_SET) ? PH_SET_HOLD
                                                                    : PH_PUL_HOLD;
                                n_pending  = CMD_NONE;
                                n_believed = r_wanted ? ST_ON : ST_OFF;
                                n_port     = r_wanted ? PORT_ON : PORT_OFF;
                                n_wait     = wait_for(energize_w);
                            end
                        end
                    endcase
                end
            end
            OP_SET: begin
                n_pending = CMD_SET;
                n_wanted  = i_item.target_on;
            end
            OP_PULSE: begin
                n_pending = CMD_PULSE;
                n_wanted  = i_item.target_on;
                n_pulse   = dur_w;
            end
            default: begin
                // toggle, ignored while the position is unknown
                if (r_believed == ST_OFF || r_believed == ST_ON) begin
                    n_pending = CMD_SET;
                    n_wanted  = (r_believed == ST_OFF);
                end
            end
        endcase
    end

    assign o_result.coil_port   = n_port;
    assign o_result.relay_state = n_believed;
    assign o_result.busy_res    = (n_phase != PH_IDLE) || (n_wait != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_wait     <= '0;
            r_pending  <= CMD_NONE;
            r_wanted   <= 1'b0;
            r_pulse    <= '0;
            r_believed <= ST_UNKNOWN;
            r_port     <= PORT_REL;
            r_energize <= ENERGIZE_RESET;
            r_recharge <= RECHARGE_RESET;
        end else begin
            if (i_step) begin
                r_phase    <= n_phase;
                r_wait     <= n_wait;
                r_pending  <= n_pending;
                r_wanted   <= n_wanted;
                r_pulse    <= n_pulse;
                r_believed <= n_believed;
                r_port     <= n_port;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_ENERGIZE: r_energize <= i_cfg_data;
                    REG_RECHARGE: r_recharge <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // coil is released exactly when no drive phase is running
    a_released_when_not_driving: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_IDLE || r_phase == PH_PUL_GAP) |-> (r_port == PORT_REL))
        else $error("coil not released outside a drive phase");

    a_driving_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_SET_HOLD || r_phase == PH_PUL_HOLD || r_phase == PH_REV_HOLD)
        |-> (r_port == PORT_ON || r_port == PORT_OFF))
        else $error("coil not driven during a hold phase");

    a_known_while_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != PH_IDLE) |-> (r_believed == ST_ON || r_believed == ST_OFF))
        else $error("position unknown while a sequence runs");

    a_port_matches_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_port == PORT_ON) |-> (r_believed == ST_ON))
        else $error("drive polarity disagrees with believed position");

    a_hold_still_without_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_step |=> ($stable(r_phase) && $stable(r_wait) && $stable(r_pending)))
        else $error("sequencer state moved without an item");

endmodule

`default_nettype wire

>>> design/bistable_relay_coil_sequencer.sv
// ----------------------------------------------------------------------------
// bistable_relay_coil_sequencer
// Top level: input register, sequencer core and result register.
// ----------------------------------------------------------------------------
// Every accepted item (tick, set, pulse or toggle) gives exactly one result,
// held in the result register after the item leaves the input register. One
// item is taken per cycle while the result side does not stall: the input
// register feeds the single-pass update in the core, which writes the state
// and the result register in the same cycle. Configuration writes take
// effect on the next edge and should be made with no item in flight.
// Durations are ticks in a TICK_BITS wide counter, saturating at the top value.
// ----------------------------------------------------------------------------
`default_nettype none

module bistable_relay_coil_sequencer import rcs_pkg::*; #(
    parameter int unsigned TICK_BITS = 24
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_valid,
    output logic                         o_stall,
    input  wire t_rcs_in                 i_data,
    output logic                         o_valid,
    input  wire logic                    i_stall,
    output t_rcs_out                     o_data,
    input  wire logic                    i_cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0] i_cfg_index,
    input  wire logic [CFG_BITS-1:0]     i_cfg_data
);

    logic     r_in_valid;
    t_rcs_in  r_in;
    logic     r_out_valid;
    t_rcs_out r_out;
    t_rcs_out result;
    logic     advance;
    logic     step;

    assign advance = !r_out_valid || !i_stall;
    assign step    = r_in_valid && advance;
    assign o_stall = r_in_valid && !advance;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    rcs_core #(
        .TICK_BITS (TICK_BITS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_item      (r_in),
        .o_result    (result),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (!o_stall) begin
                r_in_valid <= i_valid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_in <= i_data;
        end
        if (step) begin
            r_out <= result;
        end
    end

endmodule

`default_nettype wire

>>> bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Bench for the bistable relay coil sequencer. Ticks and commands go in
// through a bursty sender while the result side stalls on its own pattern.
// A predictor inside the bench keeps its own copy of the sequencer state and
// the timing registers, and each result transfer is checked field by field
// against the oldest prediction.
// ----------------------------------------------------------------------------
module tb import rcs_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 500000;

    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_SET_DRIVE,
        SEQ_PULSE_DRIVE,
        SEQ_PULSE_GAP,
        SEQ_REVERSE_DRIVE
    } t_seq_phase;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    i_valid;
    logic                    o_stall;
    t_rcs_in                 i_data;
    logic                    o_valid;
    logic                    i_stall = 1'b0;
    t_rcs_out                o_data;
    logic                    i_cfg_we;
    logic [CFG_IDX_BITS-1:0] i_cfg_index;
    logic [CFG_BITS-1:0]     i_cfg_data;

    bistable_relay_coil_sequencer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data      (i_data),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_data      (o_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // predicted sequencer state
    t_seq_phase  seq_phase   = SEQ_IDLE;
    logic [23:0] seq_wait    = '0;
    logic [1:0]  seq_pending = CMD_NONE;
    logic        seq_want_on = 1'b0;
    logic [23:0] seq_gap_len = '0;
    logic [1:0]  seq_state   = ST_UNKNOWN;
    logic [7:0]  seq_port    = PORT_REL;
    logic [15:0] cfg_energize = ENERGIZE_RESET;
    logic [15:0] cfg_recharge = RECHARGE_RESET;

    t_rcs_out coil_results_due[$];
    t_rcs_out oldest_due;
    int       mismatch_count = 0;
    int       cycle_count = 0;
    int       burst_left = 0;
    int       stall_left = 0;
    int       free_left = 0;

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: done, errors");
            $finish;
        end
    end

    // receiver stall pattern: short and long stall runs between free stretches
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            i_stall <= 1'b1;
            stall_left--;
        end else if (free_left != 0) begin
            i_stall <= 1'b0;
            free_left--;
        end else begin
            i_stall <= 1'b0;
            stall_left = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 20)
                                                     : $urandom_range(0, 3);
            free_left  = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 6);
        end
    end

    function automatic logic [23:0] hold_count(input logic [23:0] n);
        return (n == 24'd0) ? 24'd0 : n - 24'd1;
    endfunction

    function automatic logic [7:0] drive_byte(input logic [1:0] st);
        return (st == ST_ON) ? PORT_ON : PORT_OFF;
    endfunction

    function automatic t_rcs_out predict_coil_output(input t_rcs_in item);
        t_rcs_out res;
        case (item.opcode)
            OP_TICK: begin
                if (seq_wait != 24'd0) begin
                    seq_wait = seq_wait - 24'd1;
                end else begin
                    case (seq_phase)
                        SEQ_SET_DRIVE, SEQ_REVERSE_DRIVE: begin
                            seq_port  = PORT_REL;
                            seq_phase = SEQ_IDLE;
                            seq_wait  = hold_count({8'd0, cfg_recharge});
                        end
                        SEQ_PULSE_DRIVE: begin
                            seq_port  = PORT_REL;
                            seq_phase = SEQ_PULSE_GAP;
                            seq_wait  = hold_count(seq_gap_len);
                        end
                        SEQ_PULSE_GAP: begin
                            seq_state = (seq_state == ST_ON) ? ST_OFF : ST_ON;
                            seq_port  = drive_byte(seq_state);
                            seq_phase = SEQ_REVERSE_DRIVE;
                            seq_wait  = hold_count({8'd0, cfg_energize});
                        end
                        default: begin
                            seq_phase = SEQ_IDLE;
                            if (seq_pending == CMD_SET || seq_pending == CMD_PULSE) begin
                                seq_phase = (seq_pending == CMD_SET) ? SEQ_SET_DRIVE
                                                                     : SEQ_PULSE_DRIVE;
                                seq_pending = CMD_NONE;
                                seq_state = seq_want_on ? ST_ON : ST_OFF;
                                seq_port  = drive_byte(seq_state);
                                seq_wait  = hold_count({8'd0, cfg_energize});
                            end
                        end
                    endcase
                end
            end
            OP_SET: begin
                seq_pending = CMD_SET;
                seq_want_on = item.target_on;
            end
            OP_PULSE: begin
                seq_pending = CMD_PULSE;
                seq_want_on = item.target_on;
                seq_gap_len = item.pulse_ticks;
            end
            default: begin
                // toggle is dropped while the relay position is unknown
                if (seq_state == ST_OFF || seq_state == ST_ON) begin
                    seq_pending = CMD_SET;
                    seq_want_on = (seq_state == ST_OFF);
                end
            end
        endcase
        res.coil_port   = seq_port;
        res.relay_state = seq_state;
        res.busy_res    = (seq_phase != SEQ_IDLE) || (seq_wait != 24'd0);
        return res;
    endfunction

    function automatic t_rcs_in coil_item(input logic [1:0] op, input logic tgt,
                                          input logic [23:0] ticks);
        t_rcs_in item;
        item.opcode      = op;
        item.target_on   = tgt;
        item.pulse_ticks = ticks;
        return item;
    endfunction

    task automatic send_item(input t_rcs_in item);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 30);
            gap = $urandom_range(1, 8);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        burst_left--;
        i_valid <= 1'b1;
        i_data  <= item;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        coil_results_due.push_back(predict_coil_output(item));
    endtask

    // a long pulse gap latched ahead of a tick would hold the run for millions
    // of ticks, so it is replaced by a short pulse first
    task automatic send_tick();
        if (seq_gap_len > 24'd40)
            send_item(coil_item(OP_PULSE, 1'($urandom_range(0, 1)),
                                24'($urandom_range(0, 12))));
        send_item(coil_item(OP_TICK, 1'($urandom_range(0, 1)), 24'($urandom)));
    endtask

    task automatic settle_sequence();
        while (seq_phase != SEQ_IDLE || seq_wait != 24'd0 || seq_pending != CMD_NONE)
            send_tick();
    endtask

    task automatic set_config(input logic [15:0] energize, input logic [15:0] recharge);
        i_valid <= 1'b0;
        while (coil_results_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= REG_ENERGIZE;
        i_cfg_data  <= energize;
        @(posedge i_clk);
        i_cfg_index <= REG_RECHARGE;
        i_cfg_data  <= recharge;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cfg_energize = energize;
        cfg_recharge = recharge;
    endtask

    task automatic run_random_traffic(input int count);
        t_rcs_in item;
        int roll;
        repeat (count) begin
            roll = $urandom_range(0, 99);
            item = coil_item(OP_TICK, 1'($urandom_range(0, 1)), 24'($urandom));
            if (roll < 65) begin
                send_tick();
            end else begin
                if (roll < 77) begin
                    item.opcode = OP_SET;
                end else if (roll < 90) begin
                    item.opcode = OP_PULSE;
                    if ($urandom_range(0, 3) != 0)
                        item.pulse_ticks = 24'($urandom_range(0, 12));
                end else begin
                    item.opcode = OP_TOGGLE;
                end
                send_item(item);
            end
        end
    endtask

    task automatic test_unknown_state();
        send_tick();
        send_item(coil_item(OP_TOGGLE, 1'b1, 24'hFFFFFF));
        send_tick();
    endtask

    task automatic test_default_timing();
        run_random_traffic(310);
    endtask

    task automatic test_set_and_pulse();
        set_config(16'd1, 16'd1);
        settle_sequence();
        send_item(coil_item(OP_SET, 1'b1, 24'd0));
        repeat (3) send_tick();
        send_item(coil_item(OP_TOGGLE, 1'b0, 24'd0));
        repeat (2) send_tick();
        // zero gap acts like a gap of one
        send_item(coil_item(OP_PULSE, 1'b1, 24'd0));
        repeat (4) send_tick();
        // newest command wins, the last pulse also replaces the gap length
        send_item(coil_item(OP_SET, 1'b1, 24'd0));
        send_item(coil_item(OP_PULSE, 1'b0, 24'hFFFFFF));
        send_item(coil_item(OP_PULSE, 1'b1, 24'd2));
        send_tick();
        // command latched while the pulse runs
        send_item(coil_item(OP_SET, 1'b0, 24'd0));
        repeat (6) send_tick();
    endtask

    task automatic test_random_sequences();
        set_config(16'd2, 16'd4);
        run_random_traffic(310);
        set_config(16'($urandom_range(1, 5)), 16'($urandom_range(1, 8)));
        run_random_traffic(310);
        set_config(16'd3, 16'd1);
        run_random_traffic(310);
    endtask

    // settle under the short timing first so the long holds never have to run out
    task automatic test_longest_durations();
        settle_sequence();
        set_config(16'hFFFF, 16'hFFFF);
        send_item(coil_item(OP_SET, 1'($urandom_range(0, 1)), 24'd0));
        repeat (40) send_tick();
        send_item(coil_item(OP_TOGGLE, 1'b0, 24'd0));
        send_item(coil_item(OP_PULSE, 1'b1, 24'hFFFFFF));
        repeat (5) send_tick();
    endtask

    // result transfers against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (coil_results_due.size() == 0) begin
                $display("%0t: unexpected result transfer, actual %h", $time, o_data);
                mismatch_count++;
            end else begin
                oldest_due = coil_results_due.pop_front();
                if (o_data.coil_port !== oldest_due.coil_port) begin
                    $display("%0t: coil_port expected %h actual %h", $time,
                             oldest_due.coil_port, o_data.coil_port);
                    mismatch_count++;
                end
                if (o_data.relay_state !== oldest_due.relay_state) begin
                    $display("%0t: relay_state expected %0d actual %0d", $time,
                             oldest_due.relay_state, o_data.relay_state);
                    mismatch_count++;
                end
                if (o_data.busy_res !== oldest_due.busy_res) begin
                    $display("%0t: busy_res expected %0d actual %0d", $time,
                             oldest_due.busy_res, o_data.busy_res);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_data      <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= REG_ENERGIZE;
        i_cfg_data  <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_unknown_state();
        test_default_timing();
        test_set_and_pulse();
        test_random_sequences();
        test_longest_durations();

        i_valid <= 1'b0;
        while (coil_results_due.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule
